// ===== src/scan_code_key_state_tracker_macros.svh =====
// Assertion macros for the RTL of the key state tracker.
`ifndef SCAN_CODE_KEY_STATE_TRACKER_MACROS_SVH
`define SCAN_CODE_KEY_STATE_TRACKER_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define KST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define KST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/kst_pkg.sv =====
`default_nettype none
package kst_pkg;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 7;

   localparam logic [BYTE_W-1:0] BYTE_PFX_EXT  = 8'hE0;
   localparam logic [BYTE_W-1:0] BYTE_PFX_SKP1 = 8'hE1;
   localparam logic [BYTE_W-1:0] BYTE_PFX_SKP2 = 8'hE2;

   localparam logic CMD_SCAN  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_EXT  = 2'd1;
   localparam logic [1:0] PFX_SKIP = 2'd2;

   // Table update decoded from one scan byte.
   typedef struct packed {
      logic              norm_we;
      logic              ext_we;
      logic              level;
      logic [CODE_W-1:0] code;
   } wr_cmd_type;

endpackage
`default_nettype wire

// ===== src/kst_bitmem.sv =====
`default_nettype none
module kst_bitmem #(
   parameter int DEPTH  = 96,
   parameter int ADDR_W = 7
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic              wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic              rd_data
);

   logic mem_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/kst_prefix.sv =====
`default_nettype none
module kst_prefix #(
   parameter int KEY_SLOTS = 96
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic                       cmd,
   input  wire logic [kst_pkg::BYTE_W-1:0] scan_byte,
   output      kst_pkg::wr_cmd_type        wr_cmd
);
   import kst_pkg::*;

   logic [1:0]  prefix_ff, prefix_in;
   wr_cmd_type  wr_cmd_ff, wr_cmd_in;
   logic        in_range;

   assign in_range = {1'b0, scan_byte[CODE_W-1:0]} < BYTE_W'(KEY_SLOTS);

   always_comb begin
      prefix_in         = prefix_ff;
      wr_cmd_in.norm_we = 1'b0;
      wr_cmd_in.ext_we  = 1'b0;
      wr_cmd_in.level   = ~scan_byte[BYTE_W-1];
      wr_cmd_in.code    = scan_byte[CODE_W-1:0];
      if (accept && cmd == CMD_SCAN) begin
         unique case (prefix_ff)
            PFX_EXT: begin
               // The byte after E0 is always consumed, never a new prefix.
               wr_cmd_in.ext_we = in_range;
               prefix_in        = PFX_NONE;
            end
            PFX_SKIP: begin
               prefix_in = PFX_NONE;
            end
            PFX_NONE: begin
               priority if (scan_byte == BYTE_PFX_EXT) begin
                  prefix_in = PFX_EXT;
               end else if (scan_byte == BYTE_PFX_SKP1 || scan_byte == BYTE_PFX_SKP2) begin
                  prefix_in = PFX_SKIP;
               end else begin
                  wr_cmd_in.norm_we = in_range;
               end
            end
            default: begin
               prefix_in = PFX_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff         <= PFX_NONE;
         wr_cmd_ff.norm_we <= 1'b0;
         wr_cmd_ff.ext_we  <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         if (accept) begin
            wr_cmd_ff <= wr_cmd_in;
         end
      end
   end

   assign wr_cmd = wr_cmd_ff;

endmodule
`default_nettype wire

// ===== src/scan_code_key_state_tracker.sv =====
`default_nettype none
// Key state tracker for scan-code set 1 bytes from a PC keyboard.
// Input: an item is taken on a clock edge with start high and busy low.
// req_cmd = 0 feeds req_scan_byte into the tables (E0 prefix selects the
// extended table, E1/E2 make the following byte be skipped); req_cmd = 1
// asks whether key req_key_index is held in either table.
// Output: exactly one beat per item, shown for one cycle with rsp_valid high.
// rsp_key_held answers a query (0 for scan bytes); rsp_any_held and
// rsp_first_held give the lowest held normal key after the item.
// Timing: after the accept edge the WRITE state writes the tables, then the
// normal table is read one entry per cycle from entry 0 up to the first held
// key, then the beat is driven. Busy falls the cycle after the beat; the
// single read port of the normal table memory sets the read rate.
// Reset: the state memories are cleared one entry a cycle, all KEY_SLOTS
// entries, with busy high; no item is taken until the pass ends.
// The receiver cannot stall, so no beat is ever held back.
module scan_code_key_state_tracker #(
   parameter int KEY_SLOTS = 96
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic                       req_cmd,
   input  wire logic [kst_pkg::BYTE_W-1:0] req_scan_byte,
   input  wire logic [kst_pkg::BYTE_W-1:0] req_key_index,
   output      logic                       rsp_valid,
   output      logic                       rsp_key_held,
   output      logic                       rsp_any_held,
   output      logic [kst_pkg::CODE_W-1:0] rsp_first_held
);
   import kst_pkg::*;
   `include "scan_code_key_state_tracker_macros.svh"

   localparam int ADDR_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(KEY_SLOTS - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0] chk_addr_ff, chk_addr_in;
   logic              issued_all_ff, issued_all_in;
   logic              qchk_ff, qchk_in;
   logic              cmd_ff;
   logic              qok_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic              held_ff, held_in;
   logic              any_ff, any_in;
   logic [ADDR_W-1:0] first_ff, first_in;

   logic              accept;
   wr_cmd_type        wr_cmd;
   logic              norm_we, ext_we, mem_wdata;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              norm_rd, ext_rd;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   kst_prefix #(
      .KEY_SLOTS(KEY_SLOTS)
   ) u_prefix (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .scan_byte(req_scan_byte),
      .wr_cmd   (wr_cmd)
   );

   kst_bitmem #(
      .DEPTH (KEY_SLOTS),
      .ADDR_W(ADDR_W)
   ) u_normal (
      .clock  (clock),
      .wr_en  (norm_we),
      .wr_addr(wr_addr),
      .wr_data(mem_wdata),
      .rd_addr(rd_addr),
      .rd_data(norm_rd)
   );

   kst_bitmem #(
      .DEPTH (KEY_SLOTS),
      .ADDR_W(ADDR_W)
   ) u_extended (
      .clock  (clock),
      .wr_en  (ext_we),
      .wr_addr(wr_addr),
      .wr_data(mem_wdata),
      .rd_addr(rd_addr),
      .rd_data(ext_rd)
   );

   // Memory ports: the clear pass and the item's update share the write port.
   always_comb begin
      norm_we   = 1'b0;
      ext_we    = 1'b0;
      mem_wdata = 1'b0;
      wr_addr   = cnt_ff;
      rd_addr   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            norm_we = 1'b1;
            ext_we  = 1'b1;
         end
         ST_WRITE: begin
            norm_we   = wr_cmd.norm_we;
            ext_we    = wr_cmd.ext_we;
            mem_wdata = wr_cmd.level;
            wr_addr   = wr_cmd.code[ADDR_W-1:0];
            rd_addr   = qok_ff ? idx_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_valid_in  = 1'b0;
      chk_addr_in   = cnt_ff;
      issued_all_in = issued_all_ff;
      qchk_in       = 1'b0;
      held_in       = held_ff;
      any_in        = any_ff;
      first_in      = first_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               held_in  = 1'b0;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // The table write lands at this edge, so every scan read sees it.
            cnt_in        = '0;
            issued_all_in = 1'b0;
            qchk_in       = 1'b1;
            any_in        = 1'b0;
            first_in      = '0;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (qchk_ff) begin
               held_in = (cmd_ff == CMD_QUERY) && qok_ff && (norm_rd || ext_rd);
            end
            priority if (chk_valid_ff && norm_rd) begin
               any_in   = 1'b1;
               first_in = chk_addr_ff;
               state_in = ST_DONE;
            end else if (chk_valid_ff && chk_addr_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end else if (!issued_all_ff) begin
               chk_valid_in  = 1'b1;
               chk_addr_in   = cnt_ff;
               cnt_in        = cnt_ff + 1'b1;
               issued_all_in = (cnt_ff == LAST_ADDR);
            end else begin
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         chk_valid_ff  <= 1'b0;
         issued_all_ff <= 1'b0;
         qchk_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_valid_ff  <= chk_valid_in;
         issued_all_ff <= issued_all_in;
         qchk_ff       <= qchk_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff <= chk_addr_in;
      held_ff     <= held_in;
      any_ff      <= any_in;
      first_ff    <= first_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         qok_ff <= req_key_index < BYTE_W'(KEY_SLOTS);
         idx_ff <= req_key_index[ADDR_W-1:0];
      end
   end

   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_key_held   = held_ff;
   assign rsp_any_held   = any_ff;
   assign rsp_first_held = CODE_W'(first_ff);

   `KST_ASSERT(a_beat_one_cycle, rsp_valid |=> !rsp_valid, "result beat longer than one cycle")
   `KST_ASSERT(a_accept_busy, accept |=> busy, "block not busy after accepting an item")
   `KST_ASSERT(a_beat_then_idle, rsp_valid |=> !busy, "block still busy after its result beat")
   `KST_ASSERT(a_first_zero, (rsp_valid && !rsp_any_held) |-> (rsp_first_held == '0),
               "first held key nonzero while no key is held")
   `KST_ASSERT_ALWAYS(a_reset_clears, reset |=> (busy && !rsp_valid),
                      "reset did not start the clearing pass")

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import kst_pkg::*;

   localparam int KEY_SLOTS    = 96;
   localparam int LIMIT_CYCLES = 1_000_000;

   typedef struct packed {
      logic              key_held;
      logic              any_held;
      logic [CODE_W-1:0] first_held;
   } key_report_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_cmd;
   logic [BYTE_W-1:0]   req_scan_byte;
   logic [BYTE_W-1:0]   req_key_index;
   logic                rsp_valid;
   logic                rsp_key_held;
   logic                rsp_any_held;
   logic [CODE_W-1:0]   rsp_first_held;

   // Local copy of the key tables and the pending prefix.
   logic                norm_held [KEY_SLOTS];
   logic                ext_keys [KEY_SLOTS];
   logic [1:0]          prefix_state;
   key_report_type      expected_reports [$];

   int                  error_count;
   int                  scans_sent;
   int                  queries_sent;
   int                  reports_checked;
   int                  cycle_count;
   int                  idle_pct;

   scan_code_key_state_tracker #(
      .KEY_SLOTS(KEY_SLOTS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_scan_byte  (req_scan_byte),
      .req_key_index  (req_key_index),
      .rsp_valid      (rsp_valid),
      .rsp_key_held   (rsp_key_held),
      .rsp_any_held   (rsp_any_held),
      .rsp_first_held (rsp_first_held)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Updates the local tables for one accepted item and queues its report.
   task automatic record_item(input logic cmd, input logic [BYTE_W-1:0] scan,
                              input logic [BYTE_W-1:0] index);
      key_report_type    rep;
      logic [CODE_W-1:0] code;
      logic              level;
      rep   = '0;
      code  = scan[CODE_W-1:0];
      level = ~scan[7];
      if (cmd == CMD_SCAN) begin
         case (prefix_state)
            PFX_EXT: begin
               // The byte after E0 is always consumed, even if it looks like a prefix.
               if (code < KEY_SLOTS) ext_keys[code] = level;
               prefix_state = PFX_NONE;
            end
            PFX_SKIP: prefix_state = PFX_NONE;
            default: begin
               if (scan == BYTE_PFX_EXT) prefix_state = PFX_EXT;
               else if (scan == BYTE_PFX_SKP1 || scan == BYTE_PFX_SKP2)
                  prefix_state = PFX_SKIP;
               else if (code < KEY_SLOTS) norm_held[code] = level;
            end
         endcase
         scans_sent++;
      end else begin
         if (index < KEY_SLOTS) rep.key_held = norm_held[index] | ext_keys[index];
         queries_sent++;
      end
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (norm_held[i]) begin
            rep.any_held   = 1'b1;
            rep.first_held = i[CODE_W-1:0];
         end
      end
      expected_reports.push_back(rep);
   endtask

   // Drives one item and holds it until the block takes it.
   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] scan,
                            input logic [BYTE_W-1:0] index);
      @(posedge clock);
      while ($urandom_range(99) < idle_pct) @(posedge clock);
      req_cmd       <= cmd;
      req_scan_byte <= scan;
      req_key_index <= index;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      record_item(cmd, scan, index);
      start <= 1'b0;
   endtask

   task automatic send_scan(input logic [BYTE_W-1:0] scan);
      send_item(CMD_SCAN, scan, BYTE_W'($urandom_range(255)));
   endtask

   task automatic send_query(input logic [BYTE_W-1:0] index);
      send_item(CMD_QUERY, BYTE_W'($urandom_range(255)), index);
   endtask

   // Each result beat is compared with the oldest expected report.
   always @(posedge clock) begin
      key_report_type exp_rep;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected result beat: key_held=%0d any_held=%0d first_held=%0d",
                   rsp_key_held, rsp_any_held, rsp_first_held);
            error_count++;
         end else begin
            exp_rep = expected_reports.pop_front();
            reports_checked++;
            if (rsp_key_held !== exp_rep.key_held) begin
               $error("key_held: expected %0d, got %0d", exp_rep.key_held, rsp_key_held);
               error_count++;
            end
            if (rsp_any_held !== exp_rep.any_held) begin
               $error("any_held: expected %0d, got %0d", exp_rep.any_held, rsp_any_held);
               error_count++;
            end
            if (rsp_first_held !== exp_rep.first_held) begin
               $error("first_held: expected %0d, got %0d", exp_rep.first_held,
                      rsp_first_held);
               error_count++;
            end
         end
      end
   end

   task automatic test_table_extremes();
      send_query(8'd0);
      send_query(8'hFF);
      send_scan(8'h00);
      send_scan(8'h5F);
      send_query(8'd95);
      send_query(8'd96);
      send_scan(8'h60);
      send_scan(8'hFF);
      send_scan(8'h80);
      send_query(8'd0);
      send_scan(8'hDF);
   endtask

   task automatic test_prefix_sequences();
      send_scan(BYTE_PFX_EXT);
      send_scan(8'h1D);
      send_query(8'h1D);
      // A prefix byte right after E0 is taken as a key code and dropped.
      send_scan(BYTE_PFX_EXT);
      send_scan(BYTE_PFX_EXT);
      send_scan(BYTE_PFX_SKP1);
      send_scan(8'h1D);
      send_scan(BYTE_PFX_SKP2);
      send_scan(8'hC5);
      send_scan(BYTE_PFX_EXT);
      send_scan(8'h9D);
      send_query(8'h1D);
      send_scan(BYTE_PFX_EXT);
      send_scan(8'h5F);
   endtask

   // Mostly well-formed make and break sequences and key queries, with some noise mixed in.
   task automatic send_random_sequence();
      int                pick;
      logic [CODE_W-1:0] code;
      logic              brk;
      pick = $urandom_range(99);
      code = CODE_W'($urandom_range(KEY_SLOTS - 1));
      brk  = ($urandom_range(99) < 60);
      if (pick < 30) begin
         send_scan({brk, code});
      end else if (pick < 45) begin
         send_scan(BYTE_PFX_EXT);
         if ($urandom_range(9) == 0) send_scan(BYTE_W'($urandom_range(255)));
         else send_scan({brk, code});
      end else if (pick < 52) begin
         send_scan($urandom_range(1) ? BYTE_PFX_SKP1 : BYTE_PFX_SKP2);
         send_scan(BYTE_W'($urandom_range(255)));
      end else if (pick < 82) begin
         if ($urandom_range(99) < 85) send_query({1'b0, code});
         else send_query(BYTE_W'($urandom_range(255)));
      end else begin
         send_scan(BYTE_W'($urandom_range(255)));
      end
   endtask

   task automatic test_random_traffic(input int sender_idle, input int item_count);
      int first_item;
      idle_pct   = sender_idle;
      first_item = scans_sent + queries_sent;
      while (scans_sent + queries_sent - first_item < item_count) send_random_sequence();
   endtask

   initial begin
      error_count     = 0;
      scans_sent      = 0;
      queries_sent    = 0;
      reports_checked = 0;
      cycle_count     = 0;
      idle_pct        = 0;
      prefix_state    = PFX_NONE;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         norm_held[i] = 1'b0;
         ext_keys[i]  = 1'b0;
      end
      reset         = 1'b1;
      start         = 1'b0;
      req_cmd       = CMD_SCAN;
      req_scan_byte = '0;
      req_key_index = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_table_extremes();
      test_prefix_sequences();
      test_random_traffic(0, 375);
      test_random_traffic(80, 375);
      test_random_traffic(0, 375);
      test_random_traffic(25, 375);

      while (expected_reports.size() != 0) @(posedge clock);
      // Any stray beat would show up within one full table scan.
      repeat (KEY_SLOTS + 8) @(posedge clock);

      $display("Covered %0d scan bytes and %0d key queries; %0d result beats checked.",
               scans_sent, queries_sent, reports_checked);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
